/* hw/rtl/lwt_pkg.sv */
package lwt_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int BACK_WINDOW  = 5;
    localparam int AHEAD_WINDOW = 15;

    localparam logic [32:0] LOOP_LIMIT = 33'(4) << 16;
    localparam logic [32:0] PEAK_LIMIT = 33'(10) << 16;
    localparam logic [33:0] BAND_WIDTH = 34'(8) << 16;

    localparam int ENTRY_W = 128;
    localparam int NUM_W   = 49;
    localparam int DEN_W   = 17;
    localparam int ROOT_W  = 33;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [2:0] REG_LA_NEAR  = 3'd0;
    localparam logic [2:0] REG_LA_FAR   = 3'd1;
    localparam logic [2:0] REG_SPD_LOW  = 3'd2;
    localparam logic [2:0] REG_SPD_HIGH = 3'd3;
    localparam logic [2:0] REG_PATH_LEN = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_LOOP_RD0, S_LOOP_RD1, S_LOOP_GO, S_LOOP_WAIT,
        S_WIN_RD, S_WIN_GO, S_WIN_WAIT,
        S_MEAN, S_MEAN_DIV, S_MEAN_WAIT,
        S_LA, S_LA_DIV, S_LA_WAIT,
        S_WALK_RD, S_WALK_GO, S_WALK_WAIT,
        S_FIN_T, S_FIN_S, S_FIN_LATCH, S_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_dist_req;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

endpackage

/* hw/rtl/lwt_ram.sv */
module lwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/lwt_dist.sv */
module lwt_dist (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lwt_pkg::t_dist_req             i_req,
    output logic                           o_done,
    output logic [lwt_pkg::ROOT_W-1:0]     o_root
);

    logic        r_busy;
    logic [5:0]  r_step;
    logic [31:0] r_dx, r_dy;
    logic [63:0] r_sx, r_sy;
    logic [65:0] r_rad;
    logic [33:0] r_rem;
    logic [32:0] r_root;
    logic        r_done;

    logic signed [32:0] dxs, dys;
    logic [35:0]        rem_sh, trial, rem_sub;

    assign dxs     = {i_req.ax[31], i_req.ax} - {i_req.bx[31], i_req.bx};
    assign dys     = {i_req.ay[31], i_req.ay} - {i_req.by[31], i_req.by};
    assign rem_sh  = {r_rem, r_rad[65:64]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == 6'd35) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dx <= dxs[32] ? 32'(-dxs) : dxs[31:0];
            r_dy <= dys[32] ? 32'(-dys) : dys[31:0];
        end else if (r_busy) begin
            if (r_step == 6'd0) begin
                r_sx <= r_dx * r_dx;
            end else if (r_step == 6'd1) begin
                r_sy <= r_dy * r_dy;
            end else if (r_step == 6'd2) begin
                r_rad  <= {1'b0, {1'b0, r_sx} + {1'b0, r_sy}};
                r_rem  <= '0;
                r_root <= '0;
            end else begin
                // one root bit per cycle, two radicand bits shifted in
                r_rad <= {r_rad[63:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sub[33:0];
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[33:0];
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hw/rtl/lwt_div.sv */
module lwt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lwt_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [lwt_pkg::NUM_W-1:0]     o_quo
);

    logic                        r_busy;
    logic                        r_done;
    logic [5:0]                  r_cnt;
    logic [lwt_pkg::NUM_W-1:0]   r_quo;
    logic [lwt_pkg::DEN_W-1:0]   r_rem;
    logic [lwt_pkg::DEN_W-1:0]   r_den;
    logic [lwt_pkg::DEN_W:0]     rem_sh, rem_sub;

    assign rem_sh  = {r_rem, r_quo[lwt_pkg::NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(lwt_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sub[lwt_pkg::DEN_W-1:0];
                r_quo <= {r_quo[lwt_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[lwt_pkg::DEN_W-1:0];
                r_quo <= {r_quo[lwt_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/lookahead_waypoint_tracker_unit.sv */
// Pure-pursuit lookahead tracker. Load beats (tuser 0) write one waypoint entry each, at
// the accepting edge. An update beat (tuser 1) runs to completion before the next beat is
// taken: every distance goes through one shared squared-distance and bit-serial root unit,
// one point at a time, fed from the single read port of the waypoint memory. An update
// measures the loop closure, then at most 21 window points, then walks at most path_length
// points, path_length taken as clamped to 2..1024. The mean and the lookahead each go through
// a 49-step restoring divider; the mean division is skipped on the first sample and the
// lookahead division when the speed limits are equal or reversed. A finished result waits in
// the output register while the next beats are accepted.
module lookahead_waypoint_tracker_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, point_x_in, point_y_in, point_z_in, point_heading_in,
    // point_speed_in, car_x, car_y, car_speed, zero pad
    input  logic [223:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // nearest_index, target_index, command_speed, target_x, target_y, target_z,
    // target_heading, mean_distance, peak_distance, closed_loop, zero pad
    output logic [207:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);

    localparam int IW = lwt_pkg::IDX_W;

    lwt_pkg::t_state r_state, n_state;

    logic [30:0] r_la_near, r_la_far;
    logic [15:0] r_spd_low, r_spd_high;
    logic [10:0] r_path_len;

    logic [IW-1:0] r_last_nearest;
    logic [31:0]   r_mean;
    logic [15:0]   r_count;
    logic [19:0]   r_peak;

    logic [31:0]   r_car_x, r_car_y;
    logic [15:0]   r_car_spd;
    logic [IW-1:0] r_last, r_end, r_idx, r_start, r_nearest, r_target;
    logic [32:0]   r_best;
    logic          r_loop;
    logic [31:0]   r_x0, r_y0;
    logic [lwt_pkg::NUM_W-1:0] r_num;
    logic [lwt_pkg::DEN_W-1:0] r_den;
    logic          r_neg;
    logic [31:0]   r_la;
    logic [95:0]   r_tgt_xyz;
    logic [15:0]   r_tgt_hd, r_cmd_spd;
    logic          r_out_valid;
    logic [207:0]  r_out_data;

    logic                         accept;
    logic                         ram_we;
    logic [IW-1:0]                ram_raddr;
    logic [lwt_pkg::ENTRY_W-1:0]  ram_rdata;
    lwt_pkg::t_dist_req           dist_req;
    logic                         dist_done;
    logic [lwt_pkg::ROOT_W-1:0]   dist_root;
    lwt_pkg::t_div_req            div_req;
    logic                         div_done;
    logic [lwt_pkg::NUM_W-1:0]    div_quo;

    logic [10:0]        n_clamp, near0, win_end;
    logic [IW-1:0]      last_w, near_w;
    logic signed [15:0] lo_s, hi_s, cs_s, sc_s;
    logic signed [32:0] la_diff;
    logic signed [16:0] sp_diff;
    logic signed [49:0] la_prod;
    logic [47:0]        mc_prod;
    logic [33:0]        band_hi;
    logic [31:0]        q32;
    logic               out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign ram_we   = accept && (s_axis_tuser == lwt_pkg::FUNC_LOAD);
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        if (r_path_len < 11'd2) begin
            n_clamp = 11'd2;
        end else if (r_path_len > 11'(lwt_pkg::MAX_POINTS)) begin
            n_clamp = 11'(lwt_pkg::MAX_POINTS);
        end else begin
            n_clamp = r_path_len;
        end
    end
    assign last_w  = 10'(n_clamp - 11'd1);
    assign near0   = ({1'b0, r_last_nearest} > {1'b0, last_w}) ?
                     {1'b0, last_w} : {1'b0, r_last_nearest};
    assign near_w  = near0[IW-1:0];
    assign win_end = (near0 + 11'(lwt_pkg::AHEAD_WINDOW) > {1'b0, last_w}) ?
                     {1'b0, last_w} : near0 + 11'(lwt_pkg::AHEAD_WINDOW);

    assign lo_s    = $signed(r_spd_low);
    assign hi_s    = $signed(r_spd_high);
    assign cs_s    = $signed(r_car_spd);
    assign sc_s    = (cs_s < lo_s) ? lo_s : ((cs_s > hi_s) ? hi_s : cs_s);
    assign la_diff = $signed({2'b00, r_la_far}) - $signed({2'b00, r_la_near});
    assign sp_diff = 17'(sc_s) - 17'(lo_s);
    assign la_prod = la_diff * sp_diff;
    assign mc_prod = r_mean * r_count;
    assign band_hi = {2'b00, r_la} + lwt_pkg::BAND_WIDTH;
    assign q32     = div_quo[31:0];

    lwt_ram #(
        .WIDTH (lwt_pkg::ENTRY_W),
        .DEPTH (lwt_pkg::MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[9:0]),
        .i_wdata ({s_axis_tdata[137:122], s_axis_tdata[121:106], s_axis_tdata[105:74],
                   s_axis_tdata[73:42], s_axis_tdata[41:10]}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lwt_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dist_req),
        .o_done  (dist_done),
        .o_root  (dist_root)
    );

    lwt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lwt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        ram_raddr     = r_idx;
        dist_req      = '0;
        div_req.start = 1'b0;
        div_req.num   = r_num;
        div_req.den   = r_den;
        unique case (r_state)
            lwt_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser == lwt_pkg::FUNC_UPDATE) begin
                    n_state = lwt_pkg::S_LOOP_RD0;
                end
            end
            lwt_pkg::S_LOOP_RD0: begin
                ram_raddr = '0;
                n_state   = lwt_pkg::S_LOOP_RD1;
            end
            lwt_pkg::S_LOOP_RD1: begin
                ram_raddr = r_last;
                n_state   = lwt_pkg::S_LOOP_GO;
            end
            lwt_pkg::S_LOOP_GO: begin
                dist_req = '{1'b1, r_x0, r_y0, ram_rdata[31:0], ram_rdata[63:32]};
                n_state  = lwt_pkg::S_LOOP_WAIT;
            end
            lwt_pkg::S_LOOP_WAIT: begin
                if (dist_done) n_state = lwt_pkg::S_WIN_RD;
            end
            lwt_pkg::S_WIN_RD:  n_state = lwt_pkg::S_WIN_GO;
            lwt_pkg::S_WIN_GO: begin
                dist_req = '{1'b1, ram_rdata[31:0], ram_rdata[63:32], r_car_x, r_car_y};
                n_state  = lwt_pkg::S_WIN_WAIT;
            end
            lwt_pkg::S_WIN_WAIT: begin
                if (dist_done) begin
                    n_state = (r_idx == r_end) ? lwt_pkg::S_MEAN : lwt_pkg::S_WIN_RD;
                end
            end
            lwt_pkg::S_MEAN: begin
                n_state = (r_count == '0) ? lwt_pkg::S_LA : lwt_pkg::S_MEAN_DIV;
            end
            lwt_pkg::S_MEAN_DIV: begin
                div_req.start = 1'b1;
                n_state       = lwt_pkg::S_MEAN_WAIT;
            end
            lwt_pkg::S_MEAN_WAIT: begin
                if (div_done) n_state = lwt_pkg::S_LA;
            end
            lwt_pkg::S_LA: begin
                n_state = (hi_s <= lo_s) ? lwt_pkg::S_WALK_RD : lwt_pkg::S_LA_DIV;
            end
            lwt_pkg::S_LA_DIV: begin
                div_req.start = 1'b1;
                n_state       = lwt_pkg::S_LA_WAIT;
            end
            lwt_pkg::S_LA_WAIT: begin
                if (div_done) n_state = lwt_pkg::S_WALK_RD;
            end
            lwt_pkg::S_WALK_RD: n_state = lwt_pkg::S_WALK_GO;
            lwt_pkg::S_WALK_GO: begin
                dist_req = '{1'b1, ram_rdata[31:0], ram_rdata[63:32], r_car_x, r_car_y};
                n_state  = lwt_pkg::S_WALK_WAIT;
            end
            lwt_pkg::S_WALK_WAIT: begin
                if (dist_done) begin
                    if (({1'b0, dist_root} > {1'b0, r_la}) &&
                        ({1'b0, dist_root} < band_hi)) begin
                        n_state = lwt_pkg::S_FIN_T;
                    end else if (r_idx == r_last) begin
                        n_state = lwt_pkg::S_FIN_T;
                    end else begin
                        n_state = lwt_pkg::S_WALK_RD;
                    end
                end
            end
            lwt_pkg::S_FIN_T: begin
                ram_raddr = r_target;
                n_state   = lwt_pkg::S_FIN_S;
            end
            lwt_pkg::S_FIN_S: begin
                ram_raddr = (r_nearest == '0) ? IW'(1) : r_nearest;
                n_state   = lwt_pkg::S_FIN_LATCH;
            end
            lwt_pkg::S_FIN_LATCH: n_state = lwt_pkg::S_OUT;
            lwt_pkg::S_OUT: begin
                if (out_free) n_state = lwt_pkg::S_IDLE;
            end
            default: n_state = lwt_pkg::S_IDLE;
        endcase
    end

    // control and persistent tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la_near      <= '0;
            r_la_far       <= '0;
            r_spd_low      <= '0;
            r_spd_high     <= '0;
            r_path_len     <= 11'd2;
            r_last_nearest <= '0;
            r_mean         <= '0;
            r_count        <= '0;
            r_peak         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lwt_pkg::REG_LA_NEAR:  r_la_near  <= i_cfg_data;
                    lwt_pkg::REG_LA_FAR:   r_la_far   <= i_cfg_data;
                    lwt_pkg::REG_SPD_LOW:  r_spd_low  <= i_cfg_data[15:0];
                    lwt_pkg::REG_SPD_HIGH: r_spd_high <= i_cfg_data[15:0];
                    lwt_pkg::REG_PATH_LEN: r_path_len <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (r_state == lwt_pkg::S_MEAN) begin
                r_last_nearest <= r_nearest;
                if ({12'd0, r_peak} < r_best && r_best < lwt_pkg::PEAK_LIMIT) begin
                    r_peak <= r_best[19:0];
                end
                if (r_count == '0) begin
                    r_mean  <= r_best[32] ? '1 : r_best[31:0];
                    r_count <= 16'd1;
                end
            end
            if (r_state == lwt_pkg::S_MEAN_WAIT && div_done) begin
                r_mean <= (|div_quo[lwt_pkg::NUM_W-1:32]) ? '1 : q32;
                if (r_count != '1) r_count <= r_count + 16'd1;
            end
            if (r_state == lwt_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-update datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lwt_pkg::S_IDLE: begin
                r_car_x   <= s_axis_tdata[169:138];
                r_car_y   <= s_axis_tdata[201:170];
                r_car_spd <= s_axis_tdata[217:202];
                r_last    <= last_w;
                r_end     <= win_end[IW-1:0];
                r_start   <= (near_w > IW'(lwt_pkg::BACK_WINDOW)) ?
                             near_w - IW'(lwt_pkg::BACK_WINDOW) : '0;
            end
            lwt_pkg::S_LOOP_GO: begin
                r_idx <= r_start;
            end
            lwt_pkg::S_LOOP_RD1: begin
                r_x0 <= ram_rdata[31:0];
                r_y0 <= ram_rdata[63:32];
            end
            lwt_pkg::S_LOOP_WAIT: begin
                if (dist_done) r_loop <= dist_root < lwt_pkg::LOOP_LIMIT;
            end
            lwt_pkg::S_WIN_WAIT: begin
                if (dist_done) begin
                    // lowest index wins a tie
                    if (r_idx == r_start || dist_root < r_best) begin
                        r_best    <= dist_root;
                        r_nearest <= r_idx;
                    end
                    if (r_idx != r_end) r_idx <= r_idx + IW'(1);
                end
            end
            lwt_pkg::S_MEAN: begin
                r_num <= {1'b0, mc_prod} + {16'd0, r_best};
                r_den <= {1'b0, r_count} + 17'd1;
            end
            lwt_pkg::S_LA: begin
                r_idx    <= r_nearest;
                r_target <= r_loop ? '0 : r_last;
                r_la     <= {1'b0, r_la_near};
                r_neg    <= la_prod[49];
                r_num    <= la_prod[49] ? 49'(-la_prod) : la_prod[48:0];
                r_den    <= 17'(hi_s) - 17'(lo_s);
            end
            lwt_pkg::S_LA_WAIT: begin
                if (div_done) begin
                    r_la <= r_neg ? {1'b0, r_la_near} - q32 : {1'b0, r_la_near} + q32;
                end
            end
            lwt_pkg::S_WALK_WAIT: begin
                if (dist_done) begin
                    if (({1'b0, dist_root} > {1'b0, r_la}) &&
                        ({1'b0, dist_root} < band_hi)) begin
                        r_target <= r_idx;
                    end else if (r_idx != r_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end
            lwt_pkg::S_FIN_S: begin
                r_tgt_xyz <= ram_rdata[95:0];
                r_tgt_hd  <= ram_rdata[111:96];
            end
            lwt_pkg::S_FIN_LATCH: begin
                r_cmd_spd <= ram_rdata[127:112];
            end
            lwt_pkg::S_OUT: begin
                if (out_free) begin
                    r_out_data <= {7'd0, r_loop, r_peak, r_mean, r_tgt_hd, r_tgt_xyz,
                                   r_cmd_spd, r_target, r_nearest};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/lwt_checker.sv */
module lwt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [207:0] m_axis_tdata
);

    // hold the beat while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_busy_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == lwt_pkg::FUNC_UPDATE
        |=> !s_axis_tready)
        else $error("input taken while an update runs");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[199:180] < 20'd655360)
        else $error("peak distance out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind lookahead_waypoint_tracker_unit lwt_checker u_lwt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [9:0]  nearest;
        logic [9:0]  target;
        logic [15:0] cmd_speed;
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        logic [15:0] heading;
        logic [31:0] mean;
        logic [19:0] peak;
        logic        loop;
    } t_track_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [30:0]  i_cfg_data = '0;

    lookahead_waypoint_tracker_unit i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the block
    logic [31:0] wp_x [lwt_pkg::MAX_POINTS];
    logic [31:0] wp_y [lwt_pkg::MAX_POINTS];
    logic [31:0] wp_z [lwt_pkg::MAX_POINTS];
    logic [15:0] wp_hdg [lwt_pkg::MAX_POINTS];
    logic [15:0] wp_spd [lwt_pkg::MAX_POINTS];
    int unsigned prev_nearest, avg_dist, dist_samples, max_dist;
    logic [30:0] la_near, la_far;
    logic [15:0] spd_low, spd_high;
    logic [10:0] path_len;

    t_track_result track_queue[$];
    int errors, n_loads, n_updates, n_results;
    int stall_hold;
    int burst_left;

    function automatic logic [32:0] isqrt(logic [65:0] v);
        logic [33:0] root;
        logic [67:0] rem, trial;
        root = '0;
        rem = '0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 68'((v >> (2 * k)) & 66'd3);
            trial = {32'd0, root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    function automatic logic [63:0] pt_dist(logic [31:0] ax, logic [31:0] ay,
                                            logic [31:0] bx, logic [31:0] by);
        logic signed [32:0] dx, dy;
        logic [32:0] mx, my;
        logic [65:0] sq;
        dx = $signed({ax[31], ax}) - $signed({bx[31], bx});
        dy = $signed({ay[31], ay}) - $signed({by[31], by});
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
        return 64'(isqrt(sq));
    endfunction

    function automatic longint lookahead_of(logic [15:0] car_spd);
        longint lo, hi, s, prod;
        lo = longint'($signed(spd_low));
        hi = longint'($signed(spd_high));
        if (hi <= lo) return longint'(la_near);
        s = longint'($signed(car_spd));
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        prod = (longint'(la_far) - longint'(la_near)) * (s - lo);
        return longint'(la_near) + prod / (hi - lo);
    endfunction

    task automatic track_predict(logic func, logic [223:0] d);
        logic [9:0] e;
        logic [31:0] cx, cy;
        int unsigned n, last, start, stop, near_i, tgt;
        logic [63:0] best, dd, mean;
        longint la;
        logic loop;
        t_track_result r;
        e = d[9:0];
        if (func == lwt_pkg::FUNC_LOAD) begin
            wp_x[e] = d[41:10];
            wp_y[e] = d[73:42];
            wp_z[e] = d[105:74];
            wp_hdg[e] = d[121:106];
            wp_spd[e] = d[137:122];
            n_loads++;
            return;
        end
        n_updates++;
        cx = d[169:138];
        cy = d[201:170];
        n = path_len < 2 ? 2 : (path_len > lwt_pkg::MAX_POINTS ?
                                lwt_pkg::MAX_POINTS : path_len);
        last = n - 1;
        loop = pt_dist(wp_x[0], wp_y[0], wp_x[last], wp_y[last]) <
               64'(lwt_pkg::LOOP_LIMIT);
        near_i = prev_nearest > last ? last : prev_nearest;
        start = near_i > lwt_pkg::BACK_WINDOW ? near_i - lwt_pkg::BACK_WINDOW : 0;
        stop = near_i + lwt_pkg::AHEAD_WINDOW;
        if (stop > last) stop = last;
        best = 0;
        for (int unsigned i = start; i <= stop; i++) begin
            dd = pt_dist(wp_x[i], wp_y[i], cx, cy);
            if (i == start || dd < best) begin
                best = dd;
                near_i = i;
            end
        end
        prev_nearest = near_i;
        if (dist_samples == 0) mean = best;
        else mean = (64'(avg_dist) * dist_samples + best) / (64'(dist_samples) + 1);
        avg_dist = mean > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : mean[31:0];
        if (dist_samples < 65535) dist_samples++;
        if (64'(max_dist) < best && best < 64'(lwt_pkg::PEAK_LIMIT)) max_dist = best[31:0];
        la = lookahead_of(d[217:202]);
        tgt = loop ? 0 : last;
        for (int unsigned i = near_i; i <= last; i++) begin
            dd = pt_dist(wp_x[i], wp_y[i], cx, cy);
            if (longint'(dd) > la && longint'(dd) < la + longint'(lwt_pkg::BAND_WIDTH)) begin
                tgt = i;
                break;
            end
        end
        r.nearest = near_i[9:0];
        r.target = tgt[9:0];
        r.cmd_speed = wp_spd[near_i == 0 ? 1 : near_i];
        r.tx = wp_x[tgt];
        r.ty = wp_y[tgt];
        r.tz = wp_z[tgt];
        r.heading = wp_hdg[tgt];
        r.mean = avg_dist;
        r.peak = max_dist[19:0];
        r.loop = loop;
        track_queue.insert(track_queue.size(), r);
    endtask

    task automatic send_beat(logic func, logic [223:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= d;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        track_predict(func, d);
    endtask

    task automatic load_point(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [15:0] hdg, logic [15:0] spd);
        logic [223:0] d;
        d = '0;
        d[9:0] = idx[9:0];
        d[41:10] = x;
        d[73:42] = y;
        d[105:74] = z;
        d[121:106] = hdg;
        d[137:122] = spd;
        send_beat(lwt_pkg::FUNC_LOAD, d);
    endtask

    task automatic update_car(logic [31:0] x, logic [31:0] y, logic [15:0] spd);
        logic [223:0] d;
        // fill the load fields with junk; an update must ignore them
        d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        d[169:138] = x;
        d[201:170] = y;
        d[217:202] = spd;
        d[223:218] = '0;
        send_beat(lwt_pkg::FUNC_UPDATE, d);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (track_queue.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lwt_pkg::REG_LA_NEAR:  la_near = val;
            lwt_pkg::REG_LA_FAR:   la_far = val;
            lwt_pkg::REG_SPD_LOW:  spd_low = val[15:0];
            lwt_pkg::REG_SPD_HIGH: spd_high = val[15:0];
            lwt_pkg::REG_PATH_LEN: path_len = val[10:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(int near, int far, int lo, int hi, int plen);
        cfg_write(lwt_pkg::REG_LA_NEAR, 31'(near));
        cfg_write(lwt_pkg::REG_LA_FAR, 31'(far));
        cfg_write(lwt_pkg::REG_SPD_LOW, 31'(lo & 16'hFFFF));
        cfg_write(lwt_pkg::REG_SPD_HIGH, 31'(hi & 16'hFFFF));
        cfg_write(lwt_pkg::REG_PATH_LEN, 31'(plen));
    endtask

    // Lay a path on entries 0..n-1: a circle (closes the loop once its points are dense enough) or a bent line.
    task automatic load_path(int n, bit circle);
        real cxr, cyr, rad, ang, px, py, step;
        cxr = $itor($urandom_range(0, 2000)) - 1000.0;
        cyr = $itor($urandom_range(0, 2000)) - 1000.0;
        rad = 3.0 + $itor($urandom_range(0, 40)) / 10.0;
        step = 1.0 + $itor($urandom_range(0, 20)) / 10.0;
        ang = $itor($urandom_range(0, 628)) / 100.0;
        px = cxr;
        py = cyr;
        for (int i = 0; i < n; i++) begin
            if (circle) begin
                px = cxr + rad * $cos(6.2832 * i / n);
                py = cyr + rad * $sin(6.2832 * i / n);
            end else begin
                px = px + step * $cos(ang);
                py = py + step * $sin(ang);
                ang = ang + ($itor($urandom_range(0, 40)) - 20.0) / 100.0;
            end
            load_point(i, $rtoi(px * 65536.0), $rtoi(py * 65536.0), $urandom,
                       16'($signed($urandom_range(0, 51472)) - 25736), $urandom);
        end
    endtask

    // Drive the car along the loaded path with a small offset, now and then at a random position.
    task automatic drive_path(int n, int count);
        int p;
        logic [31:0] ox, oy;
        logic [15:0] spd;
        p = 0;
        for (int k = 0; k < count; k++) begin
            p = p + $urandom_range(0, 3);
            if (p >= n) p = $urandom_range(0, n - 1);
            ox = $urandom_range(0, 262144) - 131072;
            oy = $urandom_range(0, 262144) - 131072;
            if ($urandom_range(0, 9) == 0) spd = $urandom;
            else spd = $urandom_range(0, 5120) - 1280;
            if ($urandom_range(0, 19) == 0) update_car($urandom, $urandom, spd);
            else update_car(wp_x[p] + ox, wp_y[p] + oy, spd);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s mismatch: expected %h, got %h", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_track_result r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (track_queue.size() == 0) begin
                $error("result with no pending update");
                errors++;
            end else begin
                r = track_queue.pop_front();
                check_field("nearest_index", r.nearest, m_axis_tdata[9:0]);
                check_field("target_index", r.target, m_axis_tdata[19:10]);
                check_field("command_speed", r.cmd_speed, m_axis_tdata[35:20]);
                check_field("target_x", r.tx, m_axis_tdata[67:36]);
                check_field("target_y", r.ty, m_axis_tdata[99:68]);
                check_field("target_z", r.tz, m_axis_tdata[131:100]);
                check_field("target_heading", r.heading, m_axis_tdata[147:132]);
                check_field("mean_distance", r.mean, m_axis_tdata[179:148]);
                check_field("peak_distance", r.peak, m_axis_tdata[199:180]);
                check_field("closed_loop", r.loop, m_axis_tdata[200]);
            end
        end
    end

    // receiver: free-flowing stretches, random stalls, and long hold-offs on request
    int rx_cycle = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (stall_hold > 0) begin
            stall_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_cycle % 300 < 80) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= $urandom_range(0, 2) != 0;
        end
    end

    task automatic test_reset_defaults();
        load_point(0, 32'h0001_0000, 32'h0002_0000, 32'h1234_5678, 16'sd100, 16'h0180);
        load_point(1, 32'h0009_0000, 32'h0002_0000, 32'h8765_4321, -16'sd100, 16'h0240);
        update_car(32'h0001_0000, 32'h0002_0000, 16'h0100);
        update_car(32'h0009_0000, 32'h0002_8000, 16'h8000);
        wait_idle();
    endtask

    task automatic test_extremes();
        // equal points: tie on the lowest index, closed loop, nearest at entry zero
        load_point(0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'sd25736, 16'h7FFF);
        load_point(1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, -16'sd25736, 16'h8000);
        update_car(32'h0000_0000, 32'h0000_0000, 16'h7FFF);
        // far corners: loop distance wider than 32 bits, no target found
        load_point(0, 32'h8000_0000, 32'h8000_0000, 32'h0, 16'h0, 16'hAAAA);
        load_point(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555, 16'h5555, 16'h5555);
        update_car(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
        update_car(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
        wait_idle();
    endtask

    task automatic test_speed_limits();
        cfg_all(32'h0002_0000, 32'h000A_0000, 256, 2560, 12);
        load_path(12, 0);
        drive_path(12, 4);
        wait_idle();
        // equal limits, then reversed, then the full range
        cfg_all(32'h7FFF_FFFF, 0, 512, 512, 12);
        drive_path(12, 2);
        wait_idle();
        cfg_all(0, 32'h7FFF_FFFF, 3000, -3000, 12);
        drive_path(12, 2);
        wait_idle();
        cfg_all(0, 32'h7FFF_FFFF, -32768, 32767, 12);
        drive_path(12, 3);
        wait_idle();
    endtask

    task automatic test_path_length_bounds();
        // straight line at 2 m spacing plus the last table entry; a fixed 3 m lookahead
        // always finds a target two points ahead, so the walk stays on written entries
        cfg_all(32'h0003_0000, 32'h0003_0000, 0, 0, 1024);
        for (int i = 0; i < 40; i++) begin
            load_point(i, 32'(i * 131072), 32'h0, $urandom, 16'(i * 100), $urandom);
        end
        load_point(1023, 32'h0100_0000, 32'h0010_0000, $urandom, 16'h0, $urandom);
        for (int p = 12; p < 36; p += 3) begin
            update_car(32'(p * 131072), 32'h0000_4000, 16'(p * 50));
        end
        wait_idle();
        cfg_write(lwt_pkg::REG_PATH_LEN, 31'd2047);
        update_car(32'(34 * 131072), 32'h0, 16'h0100);
        update_car(32'(36 * 131072), 32'hFFFF_C000, 16'h0100);
        wait_idle();
        // shrink so the stale nearest index is clamped
        cfg_write(lwt_pkg::REG_PATH_LEN, 31'd0);
        drive_path(2, 2);
        wait_idle();
        cfg_write(lwt_pkg::REG_PATH_LEN, 31'd1);
        drive_path(2, 1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        cfg_all(32'h0002_0000, 32'h0006_0000, 0, 2048, 20);
        load_path(20, 1);
        stall_hold = 12000;
        drive_path(20, 6);
        wait_idle();
    endtask

    task automatic test_random();
        int n;
        for (int ph = 0; ph < 16; ph++) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 60) : $urandom_range(2, 20);
            if ($urandom_range(0, 5) == 0)
                cfg_all($urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF,
                        $urandom, $urandom, n);
            else
                cfg_all($urandom_range(65536, 393216), $urandom_range(131072, 1048576),
                        $urandom_range(0, 768), $urandom_range(769, 3840), n);
            load_path(n, $urandom_range(0, 1));
            // stray loads anywhere in the table
            repeat ($urandom_range(0, 2))
                load_point($urandom_range(0, 1023), $urandom, $urandom, $urandom,
                           $urandom, $urandom);
            drive_path(n, $urandom_range(5, 14));
            wait_idle();
        end
    endtask

    initial begin
        errors = 0;
        n_loads = 0;
        n_updates = 0;
        n_results = 0;
        stall_hold = 0;
        burst_left = 0;
        prev_nearest = 0;
        avg_dist = 0;
        dist_samples = 0;
        max_dist = 0;
        la_near = '0;
        la_far = '0;
        spd_low = '0;
        spd_high = '0;
        path_len = 11'd2;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_extremes();
        test_speed_limits();
        test_path_length_bounds();
        test_backpressure();
        test_random();
        wait_idle();
        $display("Covered %0d waypoint loads and %0d tracking updates, %0d results checked.",
                 n_loads, n_updates, n_results);
        if (errors == 0 && track_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
